### rtl/core/bpss_pkg.sv
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared widths, codes and types for the beacon period slot scheduler.
// ----------------------------------------------------------------------------
package bpss_pkg;

   localparam int SLOT_W    = 19;
   localparam int CALC_W    = 20;
   localparam int CFG_W     = 12;
   localparam int CFG_IDX_W = 3;
   localparam int COUNT_W   = 5;
   localparam int KIND_W    = 3;
   localparam int DEV_IDX_W = 4;

   localparam int DEF_MAX_DEVICES       = 16;
   localparam int DEF_MAX_SESSIONS      = 16;
   localparam int DEF_BLOCK_GUARD_SLOTS = 0;

   typedef enum logic [KIND_W-1:0] {
      KIND_BEACON   = 3'd0,
      KIND_PRS      = 3'd1,
      KIND_REQUEST  = 3'd2,
      KIND_AUTH     = 3'd3,
      KIND_GUARD    = 3'd4,
      KIND_RESPONSE = 3'd5,
      KIND_SUMMARY  = 3'd6
   } frame_kind_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_BEACON     = 3'd0,
      CFG_PRS        = 3'd1,
      CFG_GAP        = 3'd2,
      CFG_REQUEST    = 3'd3,
      CFG_PROCESSING = 3'd4,
      CFG_AUTH       = 3'd5,
      CFG_GUARD      = 3'd6,
      CFG_RESPONSE   = 3'd7
   } cfg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BEACON,
      ST_PRS,
      ST_HEAD,
      ST_REQ,
      ST_REQ_END,
      ST_AUTH,
      ST_GUARD,
      ST_RESP_INIT,
      ST_RESP,
      ST_SUMMARY
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BEACON,
      OP_PRS,
      OP_HEAD,
      OP_REQ,
      OP_REQ_END,
      OP_AUTH,
      OP_GUARD,
      OP_RESP_INIT,
      OP_RESP,
      OP_SUMMARY
   } op_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } ctl_cmd_type;

   typedef struct packed {
      logic beacon_zero;
      logic prs_zero;
      logic dev_none;
      logic ses_none;
      logic dev_last;
      logic out_free;
   } ctl_status_type;

endpackage

### rtl/core/bpss_channels.sv
// ----------------------------------------------------------------------------
// bpss channels
// Valid/ready channel interfaces for grants and scheduled frame items.
// ----------------------------------------------------------------------------
interface bpss_req_if
   import bpss_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] device_count;
   logic [COUNT_W-1:0] session_count;

   modport source (output valid, output device_count, output session_count, input ready);
   modport sink (input valid, input device_count, input session_count, output ready);
endinterface

interface bpss_rsp_if
   import bpss_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    frame_kind;
   logic [DEV_IDX_W-1:0] device_index;
   logic [SLOT_W-1:0]    start_slot;
   logic [SLOT_W-1:0]    end_slot;
   logic                 last;
   logic [SLOT_W-1:0]    beacon_end;
   logic [SLOT_W-1:0]    request_end;
   logic [SLOT_W-1:0]    service_end;
   logic [SLOT_W-1:0]    guard_end;
   logic [SLOT_W-1:0]    response_start;
   logic [SLOT_W-1:0]    last_frame_end;
   logic [SLOT_W-1:0]    finish_slot;

   modport source (
      output valid, output frame_kind, output device_index, output start_slot,
      output end_slot, output last, output beacon_end, output request_end,
      output service_end, output guard_end, output response_start,
      output last_frame_end, output finish_slot, input ready
   );
   modport sink (
      input valid, input frame_kind, input device_index, input start_slot,
      input end_slot, input last, input beacon_end, input request_end,
      input service_end, input guard_end, input response_start,
      input last_frame_end, input finish_slot, output ready
   );
endinterface

### rtl/core/bpss_ctrl.sv
// ----------------------------------------------------------------------------
// bpss_ctrl
// Phase sequencer: walks one grant through head, requests, service block,
// responses and summary, one datapath step per cycle when not stalled.
// ----------------------------------------------------------------------------
module bpss_ctrl
   import bpss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.fire  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = OP_LOAD;
            cmd.fire  = req_valid;
         end
         ST_BEACON: begin
            cmd.op   = OP_BEACON;
            cmd.fire = status.beacon_zero | status.out_free;
         end
         ST_PRS: begin
            cmd.op   = OP_PRS;
            cmd.fire = status.prs_zero | status.out_free;
         end
         ST_HEAD: begin
            cmd.op   = OP_HEAD;
            cmd.fire = 1'b1;
         end
         ST_REQ: begin
            cmd.op   = OP_REQ;
            cmd.fire = status.out_free;
         end
         ST_REQ_END: begin
            cmd.op   = OP_REQ_END;
            cmd.fire = 1'b1;
         end
         ST_AUTH: begin
            cmd.op   = OP_AUTH;
            cmd.fire = status.out_free;
         end
         ST_GUARD: begin
            cmd.op   = OP_GUARD;
            cmd.fire = status.out_free;
         end
         ST_RESP_INIT: begin
            cmd.op   = OP_RESP_INIT;
            cmd.fire = 1'b1;
         end
         ST_RESP: begin
            cmd.op   = OP_RESP;
            cmd.fire = status.out_free;
         end
         ST_SUMMARY: begin
            cmd.op   = OP_SUMMARY;
            cmd.fire = status.out_free;
         end
         default: begin
            cmd.op   = OP_NONE;
            cmd.fire = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (cmd.fire) begin
         case (state_ff)
            ST_IDLE:      state_in = ST_BEACON;
            ST_BEACON:    state_in = ST_PRS;
            ST_PRS:       state_in = ST_HEAD;
            ST_HEAD:      state_in = status.dev_none ? ST_REQ_END : ST_REQ;
            ST_REQ:       state_in = status.dev_last ? ST_REQ_END : ST_REQ;
            ST_REQ_END:   state_in = status.ses_none ? ST_RESP_INIT : ST_AUTH;
            ST_AUTH:      state_in = ST_GUARD;
            ST_GUARD:     state_in = ST_RESP_INIT;
            ST_RESP_INIT: state_in = status.dev_none ? ST_SUMMARY : ST_RESP;
            ST_RESP:      state_in = status.dev_last ? ST_SUMMARY : ST_RESP;
            ST_SUMMARY:   state_in = ST_IDLE;
            default:      state_in = ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/bpss_datapath.sv
// ----------------------------------------------------------------------------
// bpss_datapath
// Slot cursor, phase boundary registers, settings and the result register.
// ----------------------------------------------------------------------------
module bpss_datapath
   import bpss_pkg::*;
#(
   parameter int MAX_DEVICES       = DEF_MAX_DEVICES,
   parameter int MAX_SESSIONS      = DEF_MAX_SESSIONS,
   parameter int BLOCK_GUARD_SLOTS = DEF_BLOCK_GUARD_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic [COUNT_W-1:0]   req_device_count,
   input  logic [COUNT_W-1:0]   req_session_count,
   input  ctl_cmd_type          cmd,
   output ctl_status_type       status,
   bpss_rsp_if.source           rsp_ch
);

   localparam int DEV_W = $clog2(MAX_DEVICES + 1);
   localparam int SES_W = $clog2(MAX_SESSIONS + 1);
   localparam int LEN_W = CFG_W + SES_W;

   // settings
   logic [CFG_W-1:0] beacon_ff, prs_ff, gap_ff, request_ff;
   logic [CFG_W-1:0] processing_ff, auth_ff, guard_ff, response_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beacon_ff     <= '0;
         prs_ff        <= '0;
         gap_ff        <= '0;
         request_ff    <= '0;
         processing_ff <= '0;
         auth_ff       <= '0;
         guard_ff      <= '0;
         response_ff   <= '0;
      end else if (csr_write_enable) begin
         case (cfg_index_type'(csr_index))
            CFG_BEACON:     beacon_ff     <= csr_write_data;
            CFG_PRS:        prs_ff        <= csr_write_data;
            CFG_GAP:        gap_ff        <= csr_write_data;
            CFG_REQUEST:    request_ff    <= csr_write_data;
            CFG_PROCESSING: processing_ff <= csr_write_data;
            CFG_AUTH:       auth_ff       <= csr_write_data;
            CFG_GUARD:      guard_ff      <= csr_write_data;
            CFG_RESPONSE:   response_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // working registers
   logic [DEV_W-1:0]  n_ff, n_in, dev_ff, dev_in;
   logic [SES_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CALC_W-1:0] cur_ff, cur_in, ready_ff, ready_in;
   logic [CALC_W-1:0] bend_ff, bend_in, rend_ff, rend_in, send_ff, send_in;
   logic [CALC_W-1:0] gend_ff, gend_in, rstart_ff, rstart_in, lend_ff, lend_in;
   logic              any_ff, any_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   frame_kind_type       out_kind_ff, out_kind_in;
   logic [DEV_IDX_W-1:0] out_dev_ff, out_dev_in;
   logic [SLOT_W-1:0]    out_start_ff, out_start_in, out_end_ff, out_end_in;
   logic                 out_last_ff, out_last_in;
   logic [SLOT_W-1:0]    out_bend_ff, out_bend_in, out_rend_ff, out_rend_in;
   logic [SLOT_W-1:0]    out_send_ff, out_send_in, out_gend_ff, out_gend_in;
   logic [SLOT_W-1:0]    out_rstart_ff, out_rstart_in, out_lend_ff, out_lend_in;
   logic [SLOT_W-1:0]    out_fin_ff, out_fin_in;

   logic                 out_free;
   logic                 emit;
   frame_kind_type       emit_kind;
   logic [CALC_W-1:0]    emit_start, emit_end;
   logic [CALC_W-1:0]    req_end, resp_start, resp_end, fin;
   logic [DEV_W-1:0]     n_sat;
   logic [SES_W-1:0]     k_sat;

   assign out_free = ~out_valid_ff | rsp_ch.ready;

   assign status.beacon_zero = (beacon_ff == '0);
   assign status.prs_zero    = (prs_ff == '0);
   assign status.dev_none    = (n_ff == '0);
   assign status.ses_none    = (k_ff == '0);
   assign status.dev_last    = (dev_ff == n_ff - DEV_W'(1));
   assign status.out_free    = out_free;

   assign n_sat = (32'(req_device_count) > MAX_DEVICES) ? DEV_W'(MAX_DEVICES)
                                                          : DEV_W'(req_device_count);
   assign k_sat = (32'(req_session_count) > MAX_SESSIONS) ? SES_W'(MAX_SESSIONS)
                                                            : SES_W'(req_session_count);

   assign req_end    = cur_ff + CALC_W'(request_ff);
   assign resp_start = (cur_ff > ready_ff) ? cur_ff : ready_ff;
   assign resp_end   = resp_start + CALC_W'(response_ff);
   assign fin        = any_ff ? lend_ff + CALC_W'(BLOCK_GUARD_SLOTS) : '0;

   always_comb begin
      n_in       = n_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      dev_in     = dev_ff;
      cur_in     = cur_ff;
      ready_in   = ready_ff;
      bend_in    = bend_ff;
      rend_in    = rend_ff;
      send_in    = send_ff;
      gend_in    = gend_ff;
      rstart_in  = rstart_ff;
      lend_in    = lend_ff;
      any_in     = any_ff;
      emit       = 1'b0;
      emit_kind  = KIND_BEACON;
      emit_start = cur_ff;
      emit_end   = cur_ff;
      if (cmd.fire) begin
         case (cmd.op)
            OP_LOAD: begin
               n_in   = n_sat;
               k_in   = k_sat;
               len_in = LEN_W'(auth_ff) * LEN_W'(k_sat);
               dev_in = '0;
               cur_in = '0;
               any_in = 1'b0;
            end
            OP_BEACON: begin
               if (!status.beacon_zero) begin
                  emit      = 1'b1;
                  emit_kind = KIND_BEACON;
                  emit_end  = cur_ff + CALC_W'(beacon_ff);
                  cur_in    = emit_end;
                  any_in    = 1'b1;
               end
            end
            OP_PRS: begin
               if (!status.prs_zero) begin
                  emit      = 1'b1;
                  emit_kind = KIND_PRS;
                  emit_end  = cur_ff + CALC_W'(prs_ff);
                  cur_in    = emit_end;
                  any_in    = 1'b1;
               end
            end
            OP_HEAD: begin
               if (cur_ff != '0) begin
                  cur_in = cur_ff + CALC_W'(gap_ff);
               end
               bend_in = cur_in;
            end
            OP_REQ: begin
               emit      = 1'b1;
               emit_kind = KIND_REQUEST;
               emit_end  = req_end;
               cur_in    = req_end + CALC_W'(gap_ff);
               if (dev_ff == '0) begin
                  ready_in = req_end + CALC_W'(processing_ff);
               end
               dev_in = dev_ff + DEV_W'(1);
               any_in = 1'b1;
            end
            OP_REQ_END: begin
               rend_in = cur_ff;
               send_in = cur_ff;
               gend_in = cur_ff;
            end
            OP_AUTH: begin
               emit      = 1'b1;
               emit_kind = KIND_AUTH;
               emit_end  = cur_ff + CALC_W'(len_ff);
               cur_in    = emit_end;
               send_in   = emit_end;
               any_in    = 1'b1;
            end
            OP_GUARD: begin
               emit      = 1'b1;
               emit_kind = KIND_GUARD;
               emit_end  = cur_ff + CALC_W'(guard_ff);
               gend_in   = emit_end;
               cur_in    = emit_end + CALC_W'(gap_ff);
            end
            OP_RESP_INIT: begin
               dev_in = '0;
               if (status.dev_none) begin
                  rstart_in = cur_ff;
                  lend_in   = (gend_ff > bend_ff) ? gend_ff : bend_ff;
               end else begin
                  lend_in = cur_ff;
               end
            end
            OP_RESP: begin
               emit       = 1'b1;
               emit_kind  = KIND_RESPONSE;
               emit_start = resp_start;
               emit_end   = resp_end;
               if (dev_ff == '0) begin
                  rstart_in = resp_start;
               end
               cur_in   = resp_end + CALC_W'(gap_ff);
               lend_in  = resp_end;
               ready_in = ready_ff + CALC_W'(request_ff) + CALC_W'(gap_ff);
               dev_in   = dev_ff + DEV_W'(1);
               any_in   = 1'b1;
            end
            OP_SUMMARY: begin
               emit       = 1'b1;
               emit_kind  = KIND_SUMMARY;
               emit_start = '0;
               emit_end   = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff & ~rsp_ch.ready;
      out_kind_in   = out_kind_ff;
      out_dev_in    = out_dev_ff;
      out_start_in  = out_start_ff;
      out_end_in    = out_end_ff;
      out_last_in   = out_last_ff;
      out_bend_in   = out_bend_ff;
      out_rend_in   = out_rend_ff;
      out_send_in   = out_send_ff;
      out_gend_in   = out_gend_ff;
      out_rstart_in = out_rstart_ff;
      out_lend_in   = out_lend_ff;
      out_fin_in    = out_fin_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = emit_kind;
         out_start_in = emit_start[SLOT_W-1:0];
         out_end_in   = emit_end[SLOT_W-1:0];
         if (emit_kind == KIND_REQUEST || emit_kind == KIND_RESPONSE) begin
            out_dev_in = DEV_IDX_W'(dev_ff);
         end else begin
            out_dev_in = '0;
         end
         if (emit_kind == KIND_SUMMARY) begin
            out_last_in   = 1'b1;
            out_bend_in   = bend_ff[SLOT_W-1:0];
            out_rend_in   = rend_ff[SLOT_W-1:0];
            out_send_in   = send_ff[SLOT_W-1:0];
            out_gend_in   = gend_ff[SLOT_W-1:0];
            out_rstart_in = rstart_ff[SLOT_W-1:0];
            out_lend_in   = lend_ff[SLOT_W-1:0];
            out_fin_in    = fin[SLOT_W-1:0];
         end else begin
            out_last_in   = 1'b0;
            out_bend_in   = '0;
            out_rend_in   = '0;
            out_send_in   = '0;
            out_gend_in   = '0;
            out_rstart_in = '0;
            out_lend_in   = '0;
            out_fin_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      dev_ff        <= dev_in;
      cur_ff        <= cur_in;
      ready_ff      <= ready_in;
      bend_ff       <= bend_in;
      rend_ff       <= rend_in;
      send_ff       <= send_in;
      gend_ff       <= gend_in;
      rstart_ff     <= rstart_in;
      lend_ff       <= lend_in;
      any_ff        <= any_in;
      out_kind_ff   <= out_kind_in;
      out_dev_ff    <= out_dev_in;
      out_start_ff  <= out_start_in;
      out_end_ff    <= out_end_in;
      out_last_ff   <= out_last_in;
      out_bend_ff   <= out_bend_in;
      out_rend_ff   <= out_rend_in;
      out_send_ff   <= out_send_in;
      out_gend_ff   <= out_gend_in;
      out_rstart_ff <= out_rstart_in;
      out_lend_ff   <= out_lend_in;
      out_fin_ff    <= out_fin_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.frame_kind     = out_kind_ff;
   assign rsp_ch.device_index   = out_dev_ff;
   assign rsp_ch.start_slot     = out_start_ff;
   assign rsp_ch.end_slot       = out_end_ff;
   assign rsp_ch.last           = out_last_ff;
   assign rsp_ch.beacon_end     = out_bend_ff;
   assign rsp_ch.request_end    = out_rend_ff;
   assign rsp_ch.service_end    = out_send_ff;
   assign rsp_ch.guard_end      = out_gend_ff;
   assign rsp_ch.response_start = out_rstart_ff;
   assign rsp_ch.last_frame_end = out_lend_ff;
   assign rsp_ch.finish_slot    = out_fin_ff;

endmodule

### rtl/core/beacon_period_slot_scheduler.sv
// ----------------------------------------------------------------------------
// beacon_period_slot_scheduler
// Lays out one beacon period per grant as a run of frame items and a summary.
//
// req_ch carries one grant (device_count, session_count); it is taken only
// while no grant is in progress. rsp_ch returns the frames in air order:
// beacon, prs, one request per device, service block and packet guard when
// there are sessions, one response per device, then a summary item with
// last set. A grant of n devices gives up to 2n+5 items.
// The sequencer emits items through a single output register, loading
// the next as the held one is taken. From one accept to the next, a
// grant passes the accept step, a step per head frame even when it is
// empty, the boundary steps between phases and a step per emitted
// frame. A non-empty beacon is the first item, registered after the
// beacon step. When rsp_ch stalls, the output register holds its item
// and the sequencer waits; nothing is dropped. Settings are to be
// written on the csr port only while the block is idle; the block does
// not enforce this. Synchronous reset clears the settings to zero and
// returns the sequencer to idle with no item pending.
// ----------------------------------------------------------------------------
module beacon_period_slot_scheduler
   import bpss_pkg::*;
#(
   parameter int MAX_DEVICES       = DEF_MAX_DEVICES,
   parameter int MAX_SESSIONS      = DEF_MAX_SESSIONS,
   parameter int BLOCK_GUARD_SLOTS = DEF_BLOCK_GUARD_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   bpss_req_if.sink             req_ch,
   bpss_rsp_if.source           rsp_ch
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   bpss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpss_datapath #(
      .MAX_DEVICES       (MAX_DEVICES),
      .MAX_SESSIONS      (MAX_SESSIONS),
      .BLOCK_GUARD_SLOTS (BLOCK_GUARD_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_device_count  (req_ch.device_count),
      .req_session_count (req_ch.session_count),
      .cmd               (cmd),
      .status            (status),
      .rsp_ch            (rsp_ch)
   );

endmodule

### dv/tb_beacon_period_slot_scheduler.sv
// ----------------------------------------------------------------------------
// tb_beacon_period_slot_scheduler
// Self-checking bench for the beacon period slot scheduler. Grants are driven
// under a series of register settings, from all-zero and all-max to random
// mixes. A scoreboard lays out each accepted grant's frames and summary
// itself and checks every returned item in order, field by field. Both
// channels idle at random, with some phases running without gaps.
// ----------------------------------------------------------------------------
module tb_beacon_period_slot_scheduler;
   import bpss_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1_500_000;
   localparam int          RANDOM_PHASES    = 10;
   localparam int          GRANTS_PER_PHASE = 32;

   typedef struct {
      logic [CFG_W-1:0] beacon;
      logic [CFG_W-1:0] prs;
      logic [CFG_W-1:0] gap;
      logic [CFG_W-1:0] request;
      logic [CFG_W-1:0] processing;
      logic [CFG_W-1:0] auth;
      logic [CFG_W-1:0] guard;
      logic [CFG_W-1:0] response;
   } slot_settings_type;

   typedef struct {
      frame_kind_type       kind;
      logic [DEV_IDX_W-1:0] device;
      logic [SLOT_W-1:0]    start_slot;
      logic [SLOT_W-1:0]    end_slot;
      logic                 last;
      logic [SLOT_W-1:0]    beacon_end;
      logic [SLOT_W-1:0]    request_end;
      logic [SLOT_W-1:0]    service_end;
      logic [SLOT_W-1:0]    guard_end;
      logic [SLOT_W-1:0]    response_start;
      logic [SLOT_W-1:0]    last_frame_end;
      logic [SLOT_W-1:0]    finish_slot;
   } frame_item_type;

   class period_scoreboard;
      slot_settings_type regs;
      frame_item_type    frames_due[$];
      int unsigned       grants_seen;
      int unsigned       items_checked;
      int unsigned       mismatches;

      function new();
         regs = '{default: '0};
         grants_seen = 0;
         items_checked = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return frames_due.size();
      endfunction

      function void write_reg(cfg_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CFG_BEACON:     regs.beacon = value;
            CFG_PRS:        regs.prs = value;
            CFG_GAP:        regs.gap = value;
            CFG_REQUEST:    regs.request = value;
            CFG_PROCESSING: regs.processing = value;
            CFG_AUTH:       regs.auth = value;
            CFG_GUARD:      regs.guard = value;
            CFG_RESPONSE:   regs.response = value;
            default: ;
         endcase
      endfunction

      function frame_item_type blank_item(frame_kind_type kind);
         frame_item_type f;
         f.kind = kind;
         f.device = '0;
         f.start_slot = '0;
         f.end_slot = '0;
         f.last = 1'b0;
         f.beacon_end = '0;
         f.request_end = '0;
         f.service_end = '0;
         f.guard_end = '0;
         f.response_start = '0;
         f.last_frame_end = '0;
         f.finish_slot = '0;
         return f;
      endfunction

      function void add_frame(frame_kind_type kind, int unsigned device,
                              int unsigned first, int unsigned stop);
         frame_item_type f;
         f = blank_item(kind);
         f.device = device[DEV_IDX_W-1:0];
         f.start_slot = first[SLOT_W-1:0];
         f.end_slot = stop[SLOT_W-1:0];
         frames_due = {frames_due, f};
      endfunction

      // lays out one beacon period for an accepted grant
      function void note_grant(logic [COUNT_W-1:0] dev_req, logic [COUNT_W-1:0] ses_req);
         int unsigned n, k, cur, base, first, stop;
         int unsigned head_end, req_end, svc_end, grd_end, resp_start, frame_end, fin;
         int unsigned dev_ready [DEF_MAX_DEVICES];
         frame_item_type closing;
         n = (dev_req > DEF_MAX_DEVICES) ? DEF_MAX_DEVICES : dev_req;
         k = (ses_req > DEF_MAX_SESSIONS) ? DEF_MAX_SESSIONS : ses_req;
         base = frames_due.size();
         cur = 0;
         resp_start = 0;
         if (regs.beacon != 0) begin
            add_frame(KIND_BEACON, 0, cur, cur + regs.beacon);
            cur += regs.beacon;
         end
         if (regs.prs != 0) begin
            add_frame(KIND_PRS, 0, cur, cur + regs.prs);
            cur += regs.prs;
         end
         if (cur != 0)
            cur += regs.gap;
         head_end = cur;
         for (int d = 0; d < n; d++) begin
            stop = cur + regs.request;
            add_frame(KIND_REQUEST, d, cur, stop);
            dev_ready[d] = stop + regs.processing;
            cur = stop + ((d + 1 < n) ? regs.gap : 0);
         end
         if (n != 0)
            cur += regs.gap;
         req_end = cur;
         if (k != 0) begin
            stop = cur + regs.auth * k;
            add_frame(KIND_AUTH, 0, cur, stop);
            cur = stop;
            svc_end = cur;
            add_frame(KIND_GUARD, 0, cur, cur + regs.guard);
            cur += regs.guard;
            grd_end = cur;
            cur += regs.gap;
         end else begin
            svc_end = cur;
            grd_end = cur;
         end
         frame_end = cur;
         for (int d = 0; d < n; d++) begin
            first = (cur > dev_ready[d]) ? cur : dev_ready[d];
            stop = first + regs.response;
            add_frame(KIND_RESPONSE, d, first, stop);
            if (d == 0)
               resp_start = first;
            cur = stop + ((d + 1 < n) ? regs.gap : 0);
            frame_end = stop;
         end
         if (n == 0) begin
            resp_start = cur;
            frame_end = (grd_end > head_end) ? grd_end : head_end;
         end
         fin = (frames_due.size() == base) ? 0 : frame_end + DEF_BLOCK_GUARD_SLOTS;
         closing = blank_item(KIND_SUMMARY);
         closing.last = 1'b1;
         closing.beacon_end = head_end[SLOT_W-1:0];
         closing.request_end = req_end[SLOT_W-1:0];
         closing.service_end = svc_end[SLOT_W-1:0];
         closing.guard_end = grd_end[SLOT_W-1:0];
         closing.response_start = resp_start[SLOT_W-1:0];
         closing.last_frame_end = frame_end[SLOT_W-1:0];
         closing.finish_slot = fin[SLOT_W-1:0];
         frames_due = {frames_due, closing};
         grants_seen++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_item(frame_item_type got);
         frame_item_type want;
         if (frames_due.size() == 0) begin
            $error("unexpected frame item: kind %0d start %0d", got.kind, got.start_slot);
            mismatches++;
            return;
         end
         want = frames_due.pop_front();
         items_checked++;
         compare_field("frame_kind", want.kind, got.kind);
         compare_field("device_index", want.device, got.device);
         compare_field("start_slot", want.start_slot, got.start_slot);
         compare_field("end_slot", want.end_slot, got.end_slot);
         compare_field("last", want.last, got.last);
         compare_field("beacon_end", want.beacon_end, got.beacon_end);
         compare_field("request_end", want.request_end, got.request_end);
         compare_field("service_end", want.service_end, got.service_end);
         compare_field("guard_end", want.guard_end, got.guard_end);
         compare_field("response_start", want.response_start, got.response_start);
         compare_field("last_frame_end", want.last_frame_end, got.last_frame_end);
         compare_field("finish_slot", want.finish_slot, got.finish_slot);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = CFG_BEACON;
   logic [CFG_W-1:0]     csr_write_data = '0;

   bpss_req_if req_ch ();
   bpss_rsp_if rsp_ch ();

   beacon_period_slot_scheduler u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   period_scoreboard board = new();
   bit               steady_flow = 1'b0;
   int unsigned      cycle_count = 0;
   int unsigned      settings_applied = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_beacon_period_slot_scheduler failed");
         $finish;
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 15);
      if (r < 8)
         return 0;
      if (r < 15)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [CFG_W-1:0] pick_length();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return CFG_W'($urandom_range(0, 15));
         6: return CFG_W'($urandom_range(0, 255));
         default: return CFG_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // mostly small grants, some at and beyond the saturation point
   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return COUNT_W'($urandom_range(0, 6));
      if (r < 8)
         return COUNT_W'($urandom_range(7, 16));
      return COUNT_W'($urandom_range(17, 31));
   endfunction

   function automatic slot_settings_type make_settings(
      logic [CFG_W-1:0] beacon, logic [CFG_W-1:0] prs, logic [CFG_W-1:0] gap,
      logic [CFG_W-1:0] request, logic [CFG_W-1:0] processing, logic [CFG_W-1:0] auth,
      logic [CFG_W-1:0] guard, logic [CFG_W-1:0] response);
      slot_settings_type s;
      s.beacon = beacon;
      s.prs = prs;
      s.gap = gap;
      s.request = request;
      s.processing = processing;
      s.auth = auth;
      s.guard = guard;
      s.response = response;
      return s;
   endfunction

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(cfg_index_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      board.write_reg(idx, value);
   endtask

   task automatic apply_settings(slot_settings_type s);
      settle();
      write_reg(CFG_BEACON, s.beacon);
      write_reg(CFG_PRS, s.prs);
      write_reg(CFG_GAP, s.gap);
      write_reg(CFG_REQUEST, s.request);
      write_reg(CFG_PROCESSING, s.processing);
      write_reg(CFG_AUTH, s.auth);
      write_reg(CFG_GUARD, s.guard);
      write_reg(CFG_RESPONSE, s.response);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_grant(logic [COUNT_W-1:0] devices, logic [COUNT_W-1:0] sessions);
      int unsigned g;
      g = idle_gap();
      if (g != 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.device_count <= devices;
      req_ch.session_count <= sessions;
      do @(posedge clock); while (!req_ch.ready);
      board.note_grant(devices, sessions);
      @(negedge clock);
   endtask

   initial begin
      int unsigned g;
      rsp_ch.ready = 1'b0;
      forever begin
         g = idle_gap();
         if (g != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      frame_item_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind = frame_kind_type'(rsp_ch.frame_kind);
         got.device = rsp_ch.device_index;
         got.start_slot = rsp_ch.start_slot;
         got.end_slot = rsp_ch.end_slot;
         got.last = rsp_ch.last;
         got.beacon_end = rsp_ch.beacon_end;
         got.request_end = rsp_ch.request_end;
         got.service_end = rsp_ch.service_end;
         got.guard_end = rsp_ch.guard_end;
         got.response_start = rsp_ch.response_start;
         got.last_frame_end = rsp_ch.last_frame_end;
         got.finish_slot = rsp_ch.finish_slot;
         board.check_item(got);
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.device_count = '0;
      req_ch.session_count = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // all lengths zero after reset, including the empty period
      send_grant(0, 0);
      send_grant(1, 1);
      send_grant(31, 31);
      send_grant(16, 0);

      // every length at its maximum
      apply_settings(make_settings('1, '1, '1, '1, '1, '1, '1, '1));
      send_grant(16, 16);
      send_grant(31, 31);
      send_grant(0, 16);

      // empty head, long processing so responses wait on their devices
      apply_settings(make_settings(0, 0, 5, 3, 100, 7, 2, 4));
      send_grant(0, 0);
      send_grant(0, 3);
      send_grant(3, 0);
      send_grant(2, 17);

      // beacon only, zero-length body frames
      apply_settings(make_settings(10, 0, 0, 0, 0, 0, 0, 0));
      send_grant(0, 0);
      send_grant(5, 1);
      send_grant(2, 2);

      // prs only head, zero service per session
      apply_settings(make_settings(0, 9, 2, 6, 1, 0, 3, 8));
      send_grant(4, 5);
      send_grant(1, 0);
      send_grant(0, 1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady_flow = (p % 4 == 3);
         apply_settings(make_settings(pick_length(), pick_length(), pick_length(),
                                      pick_length(), pick_length(), pick_length(),
                                      pick_length(), pick_length()));
         repeat (GRANTS_PER_PHASE) send_grant(pick_count(), pick_count());
      end
      steady_flow = 1'b0;

      settle();
      repeat (32) @(posedge clock);

      $display("covered %0d grants under %0d register settings, %0d frame items checked",
               board.grants_seen, settings_applied + 1, board.items_checked);
      $display("%0d mismatches, %0d items still outstanding",
               board.mismatches, board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb_beacon_period_slot_scheduler passed");
      end else begin
         $display("tb_beacon_period_slot_scheduler failed");
      end
      $finish;
   end

endmodule
